FILE: rtl/ewmalt_pkg.sv
// ----------------------------------------------------------------------------
// ewmalt_pkg
// Shared types and constants for the envelope level trigger.
// ----------------------------------------------------------------------------
`default_nettype none

package ewmalt_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned AvgW    = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned OutTdataW = 24;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_ALPHA       = 2'd0,
    REG_THRESH_HIGH = 2'd1,
    REG_THRESH_LOW  = 2'd2,
    REG_REFRACTORY  = 2'd3
  } reg_idx_e;

  localparam logic [15:0] AlphaRst      = 16'd6554;
  localparam logic [15:0] ThreshHighRst = 16'd16384;
  localparam logic [15:0] ThreshLowRst  = 16'd8192;
  localparam logic [15:0] RefractoryRst = 16'd4410;

  // upper bound of the Q16.16 average (magnitude 32768)
  localparam logic [AvgW-1:0] AvgMax = 32'h8000_0000;

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] thresh_high;
    logic [15:0] thresh_low;
    logic [15:0] refractory;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/ewmalt_core.sv
// ----------------------------------------------------------------------------
// ewmalt_core
// Running average state, threshold compare and refractory counter.
// ----------------------------------------------------------------------------
`default_nettype none

module ewmalt_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                step_i,
  input  wire  [ewmalt_pkg::SampleW-1:0]     sample_i,
  input  ewmalt_pkg::cfg_t                   cfg_i,
  output logic                               fire_o,
  output logic [ewmalt_pkg::LevelW-1:0]      level_o
);

  logic [ewmalt_pkg::AvgW-1:0]   avg_q, avg_d;
  logic [ewmalt_pkg::CountW-1:0] quiet_q, quiet_d;

  logic [16:0]        mag;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic [33:0]        sum;
  logic               above, below;

  // new = avg + floor(alpha * ((mag << 16) - avg) / 65536), exact rewrite
  always_comb begin
    mag  = sample_i[15] ? (17'h10000 - {1'b0, sample_i}) : {1'b0, sample_i};
    diff = $signed({mag, 16'h0000}) - $signed({1'b0, avg_q});
    prod = $signed({1'b0, cfg_i.alpha}) * diff;
    sum  = {2'b00, avg_q} + prod[49:16];
    avg_d = sum[31:0];

    above = avg_d > {cfg_i.thresh_high, 16'h0000};
    below = avg_d < {cfg_i.thresh_low, 16'h0000};

    fire_o  = 1'b0;
    quiet_d = quiet_q;
    if (above) begin
      fire_o  = (quiet_q == '0);
      quiet_d = cfg_i.refractory;
    end else if (below && (quiet_q != '0)) begin
      quiet_d = quiet_q - 16'd1;
    end
    level_o = avg_d[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q   <= '0;
      quiet_q <= ewmalt_pkg::RefractoryRst;
    end else if (step_i) begin
      avg_q   <= avg_d;
      quiet_q <= quiet_d;
    end
  end

  a_avg_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_q <= ewmalt_pkg::AvgMax)
    else $error("average above full scale");

  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(avg_q) && $stable(quiet_q)))
    else $error("state changed without a transfer");

  a_fire_reload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && fire_o) |=> (quiet_q == $past(cfg_i.refractory)))
    else $error("refractory counter not reloaded on fire");

  a_fire_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_o |-> (quiet_q == '0))
    else $error("fire while refractory counter nonzero");

endmodule

`default_nettype wire

FILE: rtl/ewma_level_trigger_refractory.sv
// ----------------------------------------------------------------------------
// ewma_level_trigger_refractory
// Envelope follower on sample magnitude with hysteresis trigger and hold-off.
// ----------------------------------------------------------------------------
// path from input transfer to result valid: input register, then result register
// throughput: 1 item per cycle unless the output stalls; the average update
// loops through the average register around one 17x33 multiply
// reset: average clears to zero, hold-off counter loads 4410, registers take
// their defaults, both stream stages empty
`default_nettype none

module ewma_level_trigger_refractory (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // stream in
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [ewmalt_pkg::SampleW-1:0]     s_axis_tdata,   // [15:0] sample
  // stream out
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [0] fire, [16:1] level, [23:17] zero
  output logic [ewmalt_pkg::OutTdataW-1:0]   m_axis_tdata,
  // register port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [ewmalt_pkg::AddrW-1:0]       paddr,
  input  wire  [ewmalt_pkg::DataW-1:0]       pwdata,
  output logic [ewmalt_pkg::DataW-1:0]       prdata,
  output logic                               pready
);

  ewmalt_pkg::cfg_t   cfg_q;
  ewmalt_pkg::reg_idx_e idx;

  logic        in_valid_q;
  logic [15:0] in_sample_q;
  logic        out_valid_q;
  logic        out_fire_q;
  logic [15:0] out_level_q;
  logic        advance;
  logic        fire;
  logic [15:0] level;

  assign pready = 1'b1;
  assign idx    = ewmalt_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha       <= ewmalt_pkg::AlphaRst;
      cfg_q.thresh_high <= ewmalt_pkg::ThreshHighRst;
      cfg_q.thresh_low  <= ewmalt_pkg::ThreshLowRst;
      cfg_q.refractory  <= ewmalt_pkg::RefractoryRst;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        ewmalt_pkg::REG_ALPHA:       cfg_q.alpha       <= pwdata[15:0];
        ewmalt_pkg::REG_THRESH_HIGH: cfg_q.thresh_high <= pwdata[15:0];
        ewmalt_pkg::REG_THRESH_LOW:  cfg_q.thresh_low  <= pwdata[15:0];
        ewmalt_pkg::REG_REFRACTORY:  cfg_q.refractory  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ewmalt_pkg::REG_ALPHA:       prdata = {16'h0000, cfg_q.alpha};
      ewmalt_pkg::REG_THRESH_HIGH: prdata = {16'h0000, cfg_q.thresh_high};
      ewmalt_pkg::REG_THRESH_LOW:  prdata = {16'h0000, cfg_q.thresh_low};
      ewmalt_pkg::REG_REFRACTORY:  prdata = {16'h0000, cfg_q.refractory};
      default:                     prdata = '0;
    endcase
  end

  // input stage moves on when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample_q <= s_axis_tdata;
    end
    if (advance) begin
      out_fire_q  <= fire;
      out_level_q <= level;
    end
  end

  ewmalt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sample_i (in_sample_q),
    .cfg_i    (cfg_q),
    .fire_o   (fire),
    .level_o  (level)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'h00, out_level_q, out_fire_q};

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item did not reach the result register");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire
